/* src/bole_pkg.sv */
// Package for the bounded ordered list engine: default sizes, request and
// status codes, and the sequencer state type. Used by the top level in src.
package bole_pkg;

  // Default list depth and stored word width.
  localparam int unsigned CapacityDef = 32;
  localparam int unsigned WordBitsDef = 32;

  // Fixed field widths of the request and result beats.
  localparam int unsigned ReqBits   = 3;
  localparam int unsigned PosBits   = 6;
  localparam int unsigned ItemBits  = 32;
  localparam int unsigned CountBits = 6;
  localparam int unsigned StatBits  = 2;

  // Request codes; codes five to seven carry no operation.
  typedef enum logic [ReqBits-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_GET    = 3'd4
  } req_e;

  // Result status codes.
  typedef enum logic [StatBits-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_PAST_END = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SHIFT = 2'd1,
    S_GET   = 2'd2
  } state_e;

endpackage

/* src/bounded_ordered_list_engine.sv */
// Top level of the bounded ordered list engine: request decode, shift
// sequencer and result register. Depends on bole_pkg and bole_ram.
//
// An ordered list of up to CAPACITY words held in one synchronous RAM with
// one write and one read port. One request is taken at a time, and the next
// request beat is accepted only after the previous result beat has been
// taken. Push, pop, unused codes and any rejected request give their result
// in the cycle after acceptance. A get reads the RAM when it is accepted and
// registers the read word as its result in the S_GET state. Insert and remove
// move the entries behind the position one place over: the shift streams one
// RAM read and one RAM write per cycle, and the last read word is written
// back after the reads end. An insert at the end or a remove of the last
// entry moves nothing. Entries are read only after they were written, so the
// RAM needs no clearing after reset.
module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ReqBits-1:0]   req_type_i,
  input  logic [PosBits-1:0]   position_i,
  input  logic [ItemBits-1:0]  item_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ItemBits-1:0]  read_value_o,
  output logic [StatBits-1:0]  status_o,
  output logic [CountBits-1:0] entry_count_o,
  output logic                 is_full_o,
  output logic                 is_empty_o
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = (CNT_W > PosBits) ? CNT_W : PosBits;

  // Sequencer and list state.
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic [ItemBits-1:0]  res_value_q, res_value_d;
  status_e              res_status_q, res_status_d;

  // Shift bookkeeping.
  logic                 is_ins_q, is_ins_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        paddr_q, paddr_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [WORD_BITS-1:0] word_q, word_d;

  // RAM port signals.
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  // Decode helpers.
  logic                 accept;
  req_e                 req;
  logic [CW-1:0]        pos_ext, cnt_ext;
  logic                 list_full, list_empty;
  logic                 go_shift, go_get, shift_done;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign req        = req_e'(req_type_i);
  assign pos_ext    = CW'(position_i);
  assign cnt_ext    = CW'(count_q);
  assign list_full  = (count_q == CNT_W'(CAPACITY));
  assign list_empty = (count_q == '0);
  assign shift_done = (rd_cnt_q == '0) && !pend_q;

  // Requests that leave the idle state for a multi-cycle sequence.
  always_comb begin
    go_shift = 1'b0;
    go_get   = 1'b0;
    if (accept) begin
      case (req)
        REQ_INSERT: go_shift = (pos_ext < CW'(CAPACITY)) && !list_full &&
                               (pos_ext <= cnt_ext);
        REQ_REMOVE: go_shift = (pos_ext < cnt_ext);
        REQ_GET:    go_get   = (pos_ext < cnt_ext);
        default: begin
          go_shift = 1'b0;
          go_get   = 1'b0;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_shift) begin
          state_d = S_SHIFT;
        end else if (go_get) begin
          state_d = S_GET;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = S_IDLE;
        end
      end
      S_GET:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM control and result loading.
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = AW'(count_q);
    mem_wdata    = WORD_BITS'(item_value_i);
    mem_re       = 1'b0;
    mem_raddr    = AW'(position_i);
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    is_ins_d     = is_ins_q;
    rd_idx_d     = rd_idx_q;
    rd_cnt_d     = rd_cnt_q;
    pend_d       = 1'b0;
    paddr_d      = paddr_q;
    pos_d        = pos_q;
    word_d       = word_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_value_d  = '0;
          res_status_d = ST_OK;
          out_valid_d  = 1'b1;
          pos_d        = AW'(position_i);
          word_d       = WORD_BITS'(item_value_i);
          case (req)
            REQ_PUSH: begin
              if (list_full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_POP: begin
              if (!list_empty) begin
                count_d = count_q - CNT_W'(1);
              end
            end
            REQ_INSERT: begin
              if (pos_ext >= CW'(CAPACITY)) begin
                res_status_d = ST_RANGE;
              end else if (list_full) begin
                res_status_d = ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                res_status_d = ST_PAST_END;
              end else begin
                // Move entries up, starting from the last one.
                out_valid_d = 1'b0;
                is_ins_d    = 1'b1;
                rd_idx_d    = AW'(count_q - CNT_W'(1));
                rd_cnt_d    = CNT_W'(cnt_ext - pos_ext);
              end
            end
            REQ_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_RANGE;
              end else begin
                // Move entries down, starting just above the removed one.
                out_valid_d = 1'b0;
                is_ins_d    = 1'b0;
                rd_idx_d    = AW'(pos_ext + CW'(1));
                rd_cnt_d    = CNT_W'(cnt_ext - pos_ext - CW'(1));
              end
            end
            REQ_GET: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_RANGE;
              end else begin
                out_valid_d = 1'b0;
                mem_re      = 1'b1;
              end
            end
            default: res_status_d = ST_OK;
          endcase
        end
      end

      S_SHIFT: begin
        // Issue the next read of the stream.
        mem_re    = (rd_cnt_q != '0);
        mem_raddr = rd_idx_q;
        pend_d    = mem_re;
        paddr_d   = rd_idx_q;
        if (mem_re) begin
          rd_cnt_d = rd_cnt_q - CNT_W'(1);
          rd_idx_d = is_ins_q ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
        end
        // Write back the word read in the previous cycle, one place over.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = is_ins_q ? (paddr_q + AW'(1)) : (paddr_q - AW'(1));
          mem_wdata = mem_rdata;
        end else if (rd_cnt_q == '0) begin
          if (is_ins_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q;
            mem_wdata = word_q;
            count_d   = count_q + CNT_W'(1);
          end else begin
            count_d   = count_q - CNT_W'(1);
          end
          res_value_d  = '0;
          res_status_d = ST_OK;
          out_valid_d  = 1'b1;
        end
      end

      S_GET: begin
        res_value_d  = ItemBits'(mem_rdata);
        res_status_d = ST_OK;
        out_valid_d  = 1'b1;
      end

      default: out_valid_d = out_valid_q;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      is_ins_q    <= 1'b0;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      is_ins_q    <= is_ins_d;
      rd_cnt_q    <= rd_cnt_d;
      pend_q      <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    rd_idx_q     <= rd_idx_d;
    paddr_q      <= paddr_d;
    pos_q        <= pos_d;
    word_q       <= word_d;
  end

  // Entry storage.
  bole_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result beat; count and flags follow the list state, which holds still
  // while a result waits.
  assign out_valid_o   = out_valid_q;
  assign read_value_o  = res_value_q;
  assign status_o      = res_status_q;
  assign entry_count_o = CountBits'(count_q);
  assign is_full_o     = list_full;
  assign is_empty_o    = list_empty;

endmodule

/* src/bole_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; sized by the WIDTH and DEPTH parameters.
module bole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered and valid in the cycle after the read enable.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* tb/list_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the bounded ordered list engine: a behavioral copy of the list
// that predicts each result beat and checks the results in order. Depends on bole_pkg.
package list_scoreboard_pkg;
  import bole_pkg::*;

  // One expected result beat.
  typedef struct {
    logic [ItemBits-1:0]  read_value;
    status_e              status;
    logic [CountBits-1:0] entry_count;
    logic                 is_full;
    logic                 is_empty;
  } list_reply_t;

  class list_scoreboard;
    logic [ItemBits-1:0] entries [CapacityDef];
    int unsigned         fill_level;
    list_reply_t         pending_replies [$];
    int unsigned         mismatches;

    function new();
      fill_level = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request beat to the list copy and queue its result.
    function void predict_request(logic [ReqBits-1:0] req, logic [PosBits-1:0] pos,
                                  logic [ItemBits-1:0] word);
      list_reply_t reply;
      int          i;
      int unsigned idx;
      idx = pos;
      reply.read_value = '0;
      reply.status     = ST_OK;
      case (req)
        REQ_PUSH: begin
          if (fill_level >= CapacityDef) begin
            reply.status = ST_FULL;
          end else begin
            entries[fill_level] = word;
            fill_level++;
          end
        end
        REQ_POP: begin
          // Popping an empty list is a quiet no-op.
          if (fill_level > 0) fill_level--;
        end
        REQ_INSERT: begin
          // Range beats full, and full beats a gap past the end.
          if (idx >= CapacityDef) begin
            reply.status = ST_RANGE;
          end else if (fill_level >= CapacityDef) begin
            reply.status = ST_FULL;
          end else if (idx > fill_level) begin
            reply.status = ST_PAST_END;
          end else begin
            for (i = fill_level; i > idx; i--) entries[i] = entries[i-1];
            entries[idx] = word;
            fill_level++;
          end
        end
        REQ_REMOVE: begin
          if (idx >= fill_level) begin
            reply.status = ST_RANGE;
          end else begin
            for (i = idx; i + 1 < fill_level; i++) entries[i] = entries[i+1];
            fill_level--;
          end
        end
        REQ_GET: begin
          if (idx >= fill_level) reply.status = ST_RANGE;
          else reply.read_value = entries[idx];
        end
        default: begin
          // Unused request codes leave everything as it is.
        end
      endcase
      reply.entry_count = CountBits'(fill_level);
      reply.is_full     = (fill_level == CapacityDef);
      reply.is_empty    = (fill_level == 0);
      pending_replies.push_back(reply);
    endfunction

    function void compare_field(string field, logic [ItemBits-1:0] want,
                                logic [ItemBits-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result beat against the oldest expectation.
    function void check_reply(logic [ItemBits-1:0] read_value, logic [StatBits-1:0] status,
                              logic [CountBits-1:0] entry_count, logic is_full,
                              logic is_empty);
      list_reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual read_value %0h status %0d",
                 $time, read_value, status);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("read_value", want.read_value, read_value);
      compare_field("status", ItemBits'(want.status), ItemBits'(status));
      compare_field("entry_count", ItemBits'(want.entry_count), ItemBits'(entry_count));
      compare_field("is_full", ItemBits'(want.is_full), ItemBits'(is_full));
      compare_field("is_empty", ItemBits'(want.is_empty), ItemBits'(is_empty));
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for the bounded ordered list engine: clock, reset, request
// and result drivers, directed and random stimulus. Depends on bole_pkg and list_scoreboard_pkg.
module tb_top;
  import bole_pkg::*;
  import list_scoreboard_pkg::*;

  localparam int unsigned CycleLimit    = 600_000;
  localparam int unsigned ItemsPerPhase = 275;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 40;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [ReqBits-1:0]   req_type_i   = '0;
  logic [PosBits-1:0]   position_i   = '0;
  logic [ItemBits-1:0]  item_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [ItemBits-1:0]  read_value_o;
  logic [StatBits-1:0]  status_o;
  logic [CountBits-1:0] entry_count_o;
  logic                 is_full_o;
  logic                 is_empty_o;

  list_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned cycle_count    = 0;

  bounded_ordered_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit; reaching it means the block hung.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
    $display("tb: failure");
    $finish;
  end

  // Result side: check each accepted beat, then pick ready for the next cycle.
  // A requested hold-off keeps ready low for a long stretch.
  initial begin
    int unsigned holds_started;
    int unsigned hold_left;
    holds_started = 0;
    hold_left     = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_reply(read_value_o, status_o, entry_count_o, is_full_o, is_empty_o);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_started != hold_requests) begin
        holds_started++;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request beat, with an optional idle gap first, and wait for acceptance.
  task automatic send_request(logic [ReqBits-1:0] req, logic [PosBits-1:0] pos,
                              logic [ItemBits-1:0] word);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    position_i   <= pos;
    item_value_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_request(req, pos, word);
  endtask

  // Draw one random request; growing segments favor push and insert,
  // shrinking ones favor pop and remove. Most positions hit a live index.
  task automatic send_random_request(bit grow);
    logic [ReqBits-1:0]  req;
    logic [PosBits-1:0]  pos;
    logic [ItemBits-1:0] word;
    int unsigned         roll;
    int unsigned         level;
    level = sb.fill_level;
    roll  = $urandom_range(99);
    if (roll >= 97) req = ReqBits'($urandom_range((1 << ReqBits) - 1, REQ_GET + 1));
    else if (roll < (grow ? 40 : 10)) req = REQ_PUSH;
    else if (roll < (grow ? 72 : 20)) req = REQ_INSERT;
    else if (roll < (grow ? 77 : 48)) req = REQ_POP;
    else if (roll < (grow ? 85 : 78)) req = REQ_REMOVE;
    else req = REQ_GET;

    if ($urandom_range(99) < 15) pos = PosBits'($urandom_range((1 << PosBits) - 1));
    else if (req == REQ_INSERT) pos = PosBits'($urandom_range(level));
    else if (level > 0) pos = PosBits'($urandom_range(level - 1));
    else pos = '0;

    roll = $urandom_range(9);
    if (roll == 0) word = '0;
    else if (roll == 1) word = '1;
    else word = $urandom;
    send_request(req, pos, word);
  endtask

  // Main sequence.
  initial begin
    int unsigned phase;
    int unsigned items_left;
    int unsigned seg_len;
    int unsigned k;
    int          code;
    int unsigned send_pcts [4];
    int unsigned recv_pcts [4];
    bit          grow;
    send_pcts = '{0, 73, 0, 8};
    recv_pcts = '{0, 0, 73, 8};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list corners, unused codes, out-of-range indexes,
    // insert at the front, middle and end, and reads around the count.
    send_request(REQ_GET, '0, '0);
    send_request(REQ_POP, '0, '0);
    send_request(REQ_REMOVE, '0, '0);
    send_request(REQ_INSERT, 6'd1, 32'hDEAD_BEEF);
    send_request(REQ_INSERT, '1, 32'hDEAD_BEEF);
    for (code = REQ_GET + 1; code < (1 << ReqBits); code++) begin
      send_request(ReqBits'(code), '1, '1);
    end
    send_request(REQ_INSERT, '0, '1);
    send_request(REQ_PUSH, '0, '0);
    send_request(REQ_PUSH, 6'h2A, 32'hA5A5_5A5A);
    send_request(REQ_INSERT, 6'd1, 32'h1234_5678);
    send_request(REQ_INSERT, 6'd4, 32'h8000_0001);
    for (code = 0; code <= 5; code++) begin
      send_request(REQ_GET, PosBits'(code), '0);
    end
    send_request(REQ_REMOVE, 6'd1, '0);
    send_request(REQ_REMOVE, '0, '0);
    send_request(REQ_GET, '0, '0);
    send_request(REQ_REMOVE, '1, '0);
    send_request(REQ_POP, '0, '0);
    send_request(REQ_GET, '1, '0);

    // Random phases with different idling on each side; the first one also
    // holds off the result side long enough to stall the request side.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      if (phase == 0) hold_requests++;
      items_left = ItemsPerPhase;
      grow       = 1'b1;
      while (items_left > 0) begin
        seg_len = $urandom_range(70, 30);
        if (seg_len > items_left) seg_len = items_left;
        for (k = 0; k < seg_len; k++) send_random_request(grow);
        items_left -= seg_len;
        grow = !grow;
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow a few idle cycles for stray beats.
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
